@@ hdl/bbdg_pkg.sv @@
// Shared types, constants and helpers for the Bayer demosaic with gain.
package bbdg_pkg;

  localparam int WidthMax = 4096;
  localparam int ColW = 12;
  localparam int RowW = 16;
  localparam int GainW = 12;
  localparam int QueueDepth = 4;

  typedef enum logic [2:0] {
    CFG_WIDTH  = 3'd0,
    CFG_HEIGHT = 3'd1,
    CFG_RGAIN  = 3'd2,
    CFG_GGAIN  = 3'd3,
    CFG_BGAIN  = 3'd4
  } cfg_idx_t;

  // One emit job: selectors into the 3x3 window plus coordinates and flags.
  typedef struct packed {
    logic            err;
    logic [1:0]      up;
    logic [1:0]      mid;
    logic [1:0]      dn;
    logic [1:0]      lf;
    logic [1:0]      ct;
    logic [1:0]      rt;
    logic [ColW-1:0] ox;
    logic [RowW-1:0] oy;
    logic            done;
    logic            last;
  } job_t;

  // Gain multiply (q < 2^11, gain < 2^12), round half up, saturate.
  function automatic logic [7:0] gain_sat(input logic [10:0] q, input logic [GainW-1:0] g);
    logic [22:0] p;
    logic [12:0] v;
    begin
      p = 23'(q) * 23'(g) + 23'd512;
      v = p[22:10];
      gain_sat = (v > 13'd255) ? 8'd255 : v[7:0];
    end
  endfunction

endpackage

@@ hdl/bbdg_front.sv @@
// Front end: line stores, window shift and emit-job generation.
module bbdg_front (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [2:0]              cfg_index,
  input  logic [15:0]             cfg_wdata,
  input  logic                    in_tvalid,
  output logic                    in_tready,
  input  logic [7:0]              in_tdata,
  output logic                    job_valid,
  output bbdg_pkg::job_t          job [4],
  output logic [2:0]              job_cnt,
  output logic [7:0]              win_o [9],
  input  logic                    q_room
);
  import bbdg_pkg::*;

  logic [12:0] width_r;
  logic [15:0] height_r;
  logic [ColW-1:0] col_r, col_nxt;
  logic [RowW-1:0] row_r, row_nxt;
  logic [7:0] mem1 [WidthMax];
  logic [7:0] mem2 [WidthMax];
  // stage A: accepted pixel + counters, memory read in flight
  logic a_v_r, a_err_r;
  logic [7:0] a_px_r;
  logic [ColW-1:0] a_x_r;
  logic [RowW-1:0] a_y_r;
  logic [7:0] rd1_r, rd2_r;
  logic [7:0] win_r [9];
  logic size_ok, acc, run_ok, lrow, rend;
  logic [7:0] ld1, ld2;
  // forward a same-column write only happens once per row, so no hazard
  assign size_ok = (width_r >= 13'd2) && (width_r <= 13'(WidthMax)) && !width_r[0]
                   && (height_r >= 16'd2) && !height_r[0];
  assign in_tready = q_room;
  assign acc = in_tvalid && in_tready;
  assign run_ok = size_ok && ({1'b0, col_r} < width_r) && (row_r < height_r);
  assign lrow = (row_r == height_r - 16'd1);
  assign rend = ({1'b0, col_r} == width_r - 13'd1);

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (acc && run_ok) begin
      if (rend) begin
        col_nxt = '0;
        row_nxt = lrow ? '0 : row_r + 16'd1;
      end else begin
        col_nxt = col_r + 12'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= 13'd2;
      height_r <= 16'd2;
      col_r <= '0;
      row_r <= '0;
      a_v_r <= 1'b0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      if (cfg_we && cfg_index == CFG_WIDTH) begin
        width_r <= cfg_wdata[12:0];
        col_r <= '0;
        row_r <= '0;
      end
      if (cfg_we && cfg_index == CFG_HEIGHT) begin
        height_r <= cfg_wdata;
        col_r <= '0;
        row_r <= '0;
      end
      a_v_r <= acc;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      a_err_r <= !run_ok;
      a_px_r <= in_tdata;
      a_x_r <= col_r;
      a_y_r <= row_r;
      if (run_ok) begin
        rd1_r <= mem1[col_r];
        rd2_r <= mem2[col_r];
      end
    end
  end

  assign ld1 = rd1_r;
  assign ld2 = rd2_r;

  always_ff @(posedge clk) begin
    if (a_v_r && !a_err_r) begin
      mem1[a_x_r] <= a_px_r;
      mem2[a_x_r] <= ld1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 9; i++) win_r[i] <= '0;
    end else if (a_v_r && !a_err_r) begin
      for (int r = 0; r < 3; r++) begin
        win_r[r*3] <= win_r[r*3+1];
        win_r[r*3+1] <= win_r[r*3+2];
      end
      win_r[2] <= ld2;
      win_r[5] <= ld1;
      win_r[8] <= a_px_r;
    end
  end

  // Jobs are formed for the beat in stage A; the window they read is updated
  // at the same edge, so ship the post-shift window alongside.
  logic a_lrow, a_rend;
  logic [1:0] up, lf;
  logic [2:0] n;
  job_t j [4];
  assign a_lrow = (a_y_r == height_r - 16'd1);
  assign a_rend = ({1'b0, a_x_r} == width_r - 13'd1);
  always_comb begin
    for (int k = 0; k < 4; k++) j[k] = '0;
    n = '0;
    up = (a_y_r == 16'd1) ? 2'd2 : 2'd0;
    lf = (a_x_r == 12'd1) ? 2'd2 : 2'd0;
    if (a_err_r) begin
      j[0].err = 1'b1;
      n = 3'd1;
    end else if (a_y_r != '0) begin
      if (a_x_r != '0) begin
        j[n[1:0]] = '{1'b0, up, 2'd1, 2'd2, lf, 2'd1, 2'd2, a_x_r - 12'd1,
                      a_y_r - 16'd1, 1'b0, 1'b0};
        n = n + 3'd1;
        if (a_lrow) begin
          j[n[1:0]] = '{1'b0, 2'd1, 2'd2, 2'd1, lf, 2'd1, 2'd2, a_x_r - 12'd1, a_y_r,
                        1'b0, 1'b0};
          n = n + 3'd1;
        end
      end
      if (a_rend) begin
        j[n[1:0]] = '{1'b0, up, 2'd1, 2'd2, 2'd1, 2'd2, 2'd1, a_x_r, a_y_r - 16'd1,
                      1'b0, 1'b0};
        n = n + 3'd1;
        if (a_lrow) begin
          j[n[1:0]] = '{1'b0, 2'd1, 2'd2, 2'd1, 2'd1, 2'd2, 2'd1, a_x_r, a_y_r,
                        1'b1, 1'b0};
          n = n + 3'd1;
        end
      end
    end
    if (n != '0) j[n[1:0] - 2'd1].last = 1'b1;
  end

  // window as seen after this beat's shift
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_o[r*3] = win_r[r*3+1];
      win_o[r*3+1] = win_r[r*3+2];
    end
    win_o[2] = ld2;
    win_o[5] = ld1;
    win_o[8] = a_px_r;
  end

  assign job_valid = a_v_r && (n != '0);
  assign job = j;
  assign job_cnt = n;
endmodule

@@ hdl/bbdg_queue.sv @@
// Job queue between front and back; one entry holds a window and up to four jobs.
module bbdg_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_en,
  input  bbdg_pkg::job_t      wr_job [4],
  input  logic [2:0]          wr_cnt,
  input  logic [7:0]          wr_win [9],
  output logic                room,
  output logic                rd_valid,
  output bbdg_pkg::job_t      rd_job,
  output logic [7:0]          rd_win [9],
  input  logic                rd_take
);
  import bbdg_pkg::*;

  job_t jq_r [QueueDepth][4];
  logic [2:0] cq_r [QueueDepth];
  logic [7:0] wq_r [QueueDepth][9];
  logic [1:0] wp_r, rp_r, sub_r;
  logic [2:0] fill_r;
  logic pop;

  // two in flight upstream (stage A and the accepting beat) need slack
  assign room = (fill_r <= 3'd1);
  assign rd_valid = (fill_r != '0);
  assign rd_job = jq_r[rp_r][sub_r];
  assign rd_win = wq_r[rp_r];
  assign pop = rd_take && rd_valid && ({1'b0, sub_r} == cq_r[rp_r] - 3'd1);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      jq_r[wp_r] <= wr_job;
      cq_r[wp_r] <= wr_cnt;
      wq_r[wp_r] <= wr_win;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      sub_r <= '0;
      fill_r <= '0;
    end else begin
      if (wr_en) wp_r <= wp_r + 2'd1;
      if (pop) begin
        rp_r <= rp_r + 2'd1;
        sub_r <= '0;
      end else if (rd_take && rd_valid) begin
        sub_r <= sub_r + 2'd1;
      end
      fill_r <= fill_r + 3'(wr_en) - 3'(pop);
    end
  end
endmodule

@@ hdl/bbdg_back.sv @@
// Back end: interpolate from the window, apply gains, register result.
module bbdg_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [2:0]            cfg_index,
  input  logic [15:0]           cfg_wdata,
  input  logic                  j_valid,
  input  bbdg_pkg::job_t        j,
  input  logic [7:0]            win [9],
  output logic                  j_take,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [55:0]           out_tdata,
  output logic                  out_tlast
);
  import bbdg_pkg::*;

  logic [GainW-1:0] rg_r, gg_r, bg_r;
  logic [10:0] c, hz, vt, dg, rq, gq, bq;
  logic [7:0] r8, g8, b8;
  logic v_r;
  logic [55:0] d_r;
  logic l_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rg_r <= 12'd256;
      gg_r <= 12'd256;
      bg_r <= 12'd256;
    end else if (cfg_we) begin
      if (cfg_index == CFG_RGAIN) rg_r <= cfg_wdata[11:0];
      if (cfg_index == CFG_GGAIN) gg_r <= cfg_wdata[11:0];
      if (cfg_index == CFG_BGAIN) bg_r <= cfg_wdata[11:0];
    end
  end

  always_comb begin
    c  = 11'(win[j.mid*3 + j.ct]);
    hz = 11'(win[j.mid*3 + j.lf]) + 11'(win[j.mid*3 + j.rt]);
    vt = 11'(win[j.up*3 + j.ct]) + 11'(win[j.dn*3 + j.ct]);
    dg = 11'(win[j.up*3 + j.lf]) + 11'(win[j.up*3 + j.rt])
       + 11'(win[j.dn*3 + j.lf]) + 11'(win[j.dn*3 + j.rt]);
    if (j.ox[0] == j.oy[0]) begin
      gq = hz + vt;
      rq = j.oy[0] ? dg : {c[8:0], 2'b00};
      bq = j.oy[0] ? {c[8:0], 2'b00} : dg;
    end else begin
      gq = {c[8:0], 2'b00};
      rq = j.oy[0] ? {vt[9:0], 1'b0} : {hz[9:0], 1'b0};
      bq = j.oy[0] ? {hz[9:0], 1'b0} : {vt[9:0], 1'b0};
    end
    r8 = gain_sat(rq, rg_r);
    g8 = gain_sat(gq, gg_r);
    b8 = gain_sat(bq, bg_r);
  end

  assign j_take = j_valid && (!v_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= 1'b0;
    else if (!v_r || out_tready) v_r <= j_valid;
  end

  always_ff @(posedge clk) begin
    if (j_take) begin
      if (j.err) begin
        d_r <= {2'd0, 1'b1, 53'd0};
        l_r <= 1'b1;
      end else begin
        d_r <= {2'd0, 1'b0, j.done, j.oy, j.ox, b8, g8, r8};
        l_r <= j.last;
      end
    end
  end

  assign out_tvalid = v_r;
  assign out_tdata = d_r;
  assign out_tlast = l_r;
endmodule

@@ hdl/bayer_bilinear_demosaic_gain.sv @@
// Top level: RGGB bilinear demosaic with per-channel gain.
// channel | dir | fields
// in_     | in  | tdata: raw_pixel[7:0]
// out_    | out | tdata: red, green, blue, out_column, out_row, frame_done, status; tlast
// cfg_    | in  | we, index 0..4, wdata[15:0]
// One pixel a cycle while the job queue has room; up to four results per pixel on the last row.
// A four-entry job queue decouples the line-store front from the gain back end.
// Synchronous active-low reset clears counters, queue and window; line stores are not cleared.
// in_tready drops while the queue holds two or more entries.
module bayer_bilinear_demosaic_gain (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // raw_pixel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // red, green, blue, out_column, out_row, frame_done, status
  output logic        out_tlast
);
  import bbdg_pkg::*;

  logic jv, room, qv, take;
  job_t jobs [4];
  job_t qj;
  logic [2:0] jc;
  logic [7:0] fw [9];
  logic [7:0] qw [9];

  bbdg_front u_front (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_wdata, .in_tvalid, .in_tready, .in_tdata,
    .job_valid(jv), .job(jobs), .job_cnt(jc), .win_o(fw), .q_room(room)
  );

  bbdg_queue u_queue (
    .clk, .rst_n, .wr_en(jv), .wr_job(jobs), .wr_cnt(jc), .wr_win(fw), .room,
    .rd_valid(qv), .rd_job(qj), .rd_win(qw), .rd_take(take)
  );

  bbdg_back u_back (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_wdata, .j_valid(qv), .j(qj), .win(qw),
    .j_take(take), .out_tvalid, .out_tready, .out_tdata, .out_tlast
  );
endmodule
